// ----- rtl/line_assembler_ring_top_assert.svh -----
// Assertion macros for the line assembler ring checks.
`ifndef LINE_ASSEMBLER_RING_TOP_ASSERT_SVH
`define LINE_ASSEMBLER_RING_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LAR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LAR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/lar_pkg.sv -----
package lar_pkg;

  localparam int LINE_MAX_DEF   = 64;
  localparam int RING_DEPTH_DEF = 8;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_RETURN  = 8'h0D;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_NEWLINE,
    KIND_POLL
  } item_kind_t;

  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  data;
  } item_t;

endpackage

// ----- rtl/lar_front.sv -----
module lar_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          opcode,
  input  logic [7:0]    rx_byte,
  input  logic          q_pop,
  output logic          busy,
  output logic          q_valid,
  output lar_pkg::item_t q_item
);

  lar_pkg::item_t                 entries [lar_pkg::QUEUE_DEPTH];
  logic [lar_pkg::QIDX_W-1:0]     wr_ptr, rd_ptr;
  logic [lar_pkg::QCNT_W-1:0]     count, count_next;
  logic                           accept, push;
  lar_pkg::item_t                 item_in;

  assign accept = start && !busy;

  // classify; carriage returns are consumed here and never queued
  always_comb begin
    item_in.data = rx_byte;
    push         = accept;
    if (opcode == lar_pkg::OP_POLL) begin
      item_in.kind = lar_pkg::KIND_POLL;
    end else if (rx_byte == lar_pkg::CH_NEWLINE) begin
      item_in.kind = lar_pkg::KIND_NEWLINE;
    end else begin
      item_in.kind = lar_pkg::KIND_BYTE;
      if (rx_byte == lar_pkg::CH_RETURN) begin
        push = 1'b0;
      end
    end
  end

  assign count_next = count + lar_pkg::QCNT_W'(push) - lar_pkg::QCNT_W'(q_pop);
  assign busy       = (count == lar_pkg::QCNT_W'(lar_pkg::QUEUE_DEPTH));
  assign q_valid    = (count != '0);
  assign q_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == lar_pkg::QIDX_W'(lar_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == lar_pkg::QIDX_W'(lar_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
    end
  end

endmodule

// ----- rtl/lar_back.sv -----
module lar_back #(
  parameter int LINE_MAX   = lar_pkg::LINE_MAX_DEF,
  parameter int RING_DEPTH = lar_pkg::RING_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  lar_pkg::item_t q_item,
  output logic           q_pop,
  output logic           strobe,
  output logic           line_found,
  output logic [7:0]     char_out,
  output logic [5:0]     line_length,
  output logic           last
);

  localparam int PW        = $clog2(LINE_MAX);
  localparam int SW        = $clog2(RING_DEPTH);
  localparam int MEM_DEPTH = RING_DEPTH * (2 ** PW);

  typedef enum logic {S_IDLE, S_STREAM} state_t;

  // Lines are assembled straight into the slot at wslot; that slot is never
  // holding a stored line, so committing a line is just a length write.
  logic [7:0]    chars   [MEM_DEPTH];
  logic [PW-1:0] len_mem [RING_DEPTH];

  state_t        state;
  logic [PW-1:0] pos, k, cur_len;
  logic [SW-1:0] wslot, rslot, wnext, rnext;
  logic [7:0]    rd_data;
  logic          full, empty, pos_max, do_byte, do_line, do_poll;

  assign wnext   = (wslot == SW'(RING_DEPTH - 1)) ? '0 : wslot + 1'b1;
  assign rnext   = (rslot == SW'(RING_DEPTH - 1)) ? '0 : rslot + 1'b1;
  assign full    = (wnext == rslot);
  assign empty   = (rslot == wslot);
  assign pos_max = (pos == PW'(LINE_MAX - 1));

  assign q_pop   = (state == S_IDLE) && q_valid;
  assign do_byte = q_pop && (q_item.kind == lar_pkg::KIND_BYTE);
  assign do_line = q_pop && (q_item.kind == lar_pkg::KIND_NEWLINE);
  assign do_poll = q_pop && (q_item.kind == lar_pkg::KIND_POLL);

  assign char_out = line_found ? rd_data : 8'd0;

  always_ff @(posedge clk) begin
    if (do_byte && !pos_max) begin
      chars[{wslot, pos}] <= q_item.data;
    end
    if (state == S_STREAM) begin
      rd_data <= chars[{rslot, k}];
    end
    if (do_line && (pos != '0) && !full) begin
      len_mem[wslot] <= pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pos         <= '0;
      wslot       <= '0;
      rslot       <= '0;
      k           <= '0;
      cur_len     <= '0;
      strobe      <= 1'b0;
      line_found  <= 1'b0;
      line_length <= '0;
      last        <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (do_byte) begin
            // overlong line: drop the byte and the partial line
            pos <= pos_max ? '0 : pos + 1'b1;
          end
          if (do_line) begin
            if ((pos != '0) && !full) begin
              wslot <= wnext;
            end
            pos <= '0;
          end
          if (do_poll) begin
            if (empty) begin
              strobe      <= 1'b1;
              line_found  <= 1'b0;
              line_length <= '0;
              last        <= 1'b1;
            end else begin
              cur_len <= len_mem[rslot];
              k       <= '0;
              state   <= S_STREAM;
            end
          end
        end
        S_STREAM: begin
          strobe      <= 1'b1;
          line_found  <= 1'b1;
          line_length <= 6'(cur_len);
          last        <= (PW'(k + 1'b1) == cur_len);
          k           <= k + 1'b1;
          if (PW'(k + 1'b1) == cur_len) begin
            rslot <= rnext;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- rtl/line_assembler_ring_top.sv -----
// Byte: queued on acceptance, popped by the idle engine; 1 per cycle while not streaming.
// Poll, empty ring: the single result is registered once the line engine pops the poll.
// Poll, stored line: once the poll is popped, the line streams out one character per cycle;
// the line engine pops no further command until the last character is out.
// busy rises only when the two-entry command queue is full; results cannot be stalled.
// rst (synchronous) empties the queue and ring and clears the assembly position.
module line_assembler_ring_top #(
  parameter int LINE_MAX   = lar_pkg::LINE_MAX_DEF,
  parameter int RING_DEPTH = lar_pkg::RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       opcode,
  input  logic [7:0] rx_byte,
  output logic       strobe,
  output logic       line_found,
  output logic [7:0] char_out,
  output logic [5:0] line_length,
  output logic       last
);

  logic           q_valid, q_pop;
  lar_pkg::item_t q_item;

  lar_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .opcode  (opcode),
    .rx_byte (rx_byte),
    .q_pop   (q_pop),
    .busy    (busy),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  lar_back #(
    .LINE_MAX   (LINE_MAX),
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .strobe      (strobe),
    .line_found  (line_found),
    .char_out    (char_out),
    .line_length (line_length),
    .last        (last)
  );

endmodule

// ----- rtl/lar_checker.sv -----
`include "line_assembler_ring_top_assert.svh"

module lar_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       opcode,
  input logic [7:0] rx_byte,
  input logic       strobe,
  input logic       line_found,
  input logic [7:0] char_out,
  input logic [5:0] line_length,
  input logic       last
);

  // an empty-ring answer is a single zeroed transfer
  `LAR_ASSERT_NOW(a_empty_reply, strobe && !line_found, last && line_length == 6'd0 && char_out == 8'd0)

  // a line streams without gaps until its last character
  `LAR_ASSERT_NEXT(a_stream_gapless, strobe && line_found && !last, strobe && line_found)

  // length stays fixed across one line
  `LAR_ASSERT_NEXT(a_len_stable, strobe && line_found && !last, $stable(line_length))

  // a stored line is never empty
  `LAR_ASSERT_NOW(a_len_nonzero, strobe && line_found, line_length != 6'd0 || last)

endmodule

bind line_assembler_ring_top lar_checker u_lar_checker (.*);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int LMAX        = lar_pkg::LINE_MAX_DEF;
  localparam int RDEPTH      = lar_pkg::RING_DEPTH_DEF;
  localparam int RAND_ITEMS  = 480;
  localparam int DRAIN_WAIT  = 80;       // longest poll stream plus pipeline
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic       found;
    logic [7:0] ch;
    logic [5:0] len;
    logic       last;
  } line_result_t;

  class line_ring_scoreboard;
    logic [7:0]   asm_buf [LMAX];
    logic [7:0]   slot_text [RDEPTH][LMAX];
    int unsigned  slot_len [RDEPTH];
    int unsigned  asm_pos, wr_slot, rd_slot;
    line_result_t expected_chars [$];
    int unsigned  errors, results_seen, lines_stored, lines_full_drop, lines_overlong;
    int unsigned  empty_polls, line_polls, transfers;

    function new();
      asm_pos = 0; wr_slot = 0; rd_slot = 0;
      errors = 0; results_seen = 0; lines_stored = 0; lines_full_drop = 0;
      lines_overlong = 0; empty_polls = 0; line_polls = 0; transfers = 0;
    endfunction

    function int unsigned pending();
      return expected_chars.size();
    endfunction

    // accepted input: advance the predicted ring and queue the poll output
    function void note_transfer(logic op, logic [7:0] b);
      int unsigned  nxt;
      line_result_t r;
      transfers++;
      if (op == lar_pkg::OP_POLL) begin
        if (rd_slot == wr_slot) begin
          r = '{found: 1'b0, ch: 8'h00, len: 6'd0, last: 1'b1};
          expected_chars.push_back(r);
          empty_polls++;
        end else begin
          for (int k = 0; k < slot_len[rd_slot]; k++) begin
            r.found = 1'b1;
            r.ch    = slot_text[rd_slot][k];
            r.len   = slot_len[rd_slot][5:0];
            r.last  = (k + 1 == slot_len[rd_slot]);
            expected_chars.push_back(r);
          end
          rd_slot = (rd_slot + 1) % RDEPTH;
          line_polls++;
        end
      end else if (b == lar_pkg::CH_NEWLINE) begin
        if (asm_pos > 0) begin
          nxt = (wr_slot + 1) % RDEPTH;
          if (nxt != rd_slot) begin
            for (int k = 0; k < asm_pos; k++) slot_text[wr_slot][k] = asm_buf[k];
            slot_len[wr_slot] = asm_pos;
            wr_slot = nxt;
            lines_stored++;
          end else begin
            lines_full_drop++;
          end
        end
        asm_pos = 0;
      end else if (b != lar_pkg::CH_RETURN) begin
        if (asm_pos < LMAX - 1) begin
          asm_buf[asm_pos] = b;
          asm_pos++;
        end else begin
          asm_pos = 0;
          lines_overlong++;
        end
      end
    endfunction

    function void match(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
      end
    endfunction

    function void check_result(logic found, logic [7:0] ch, logic [5:0] len, logic last);
      line_result_t e;
      results_seen++;
      if (expected_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual found=%0b char=0x%0h len=%0d last=%0b",
                 $time, found, ch, len, last);
        return;
      end
      e = expected_chars.pop_front();
      match("line_found", e.found, found);
      match("char_out", e.ch, ch);
      match("line_length", e.len, len);
      match("last", e.last, last);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       start;
  logic       busy;
  logic       opcode;
  logic [7:0] rx_byte;
  logic       strobe;
  logic       line_found;
  logic [7:0] char_out;
  logic [5:0] line_length;
  logic       last;
  int         cycles = 0;

  line_ring_scoreboard sb;

  always #2 clk = ~clk;

  line_assembler_ring_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .rx_byte(rx_byte),
    .strobe(strobe), .line_found(line_found), .char_out(char_out),
    .line_length(line_length), .last(last)
  );

  always @(posedge clk) begin
    if (!rst && strobe) sb.check_result(line_found, char_out, line_length, last);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, sb.pending());
      $display("FAIL line_assembler_ring_top");
      $finish;
    end
  end

  // hold start until a transfer happens (busy low at the edge)
  task automatic send_item(logic op, logic [7:0] b);
    @(negedge clk);
    start   <= 1'b1;
    opcode  <= op;
    rx_byte <= b;
    do @(posedge clk); while (busy);
    sb.note_transfer(op, b);
  endtask

  task automatic sender_gap(bit burst);
    int r;
    int g;
    r = $urandom_range(0, 99);
    g = 0;
    if (!burst) begin
      if (r >= 92) g = $urandom_range(10, 40);
      else if (r >= 60) g = $urandom_range(1, 3);
    end
    if (g > 0) begin
      @(negedge clk);
      start   <= 1'b0;
      rx_byte <= 8'($urandom_range(0, 255));
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] line_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 255));
    if (v == lar_pkg::CH_NEWLINE) v = 8'h0B;
    if ($urandom_range(0, 11) == 0) v = lar_pkg::CH_RETURN;
    return v;
  endfunction

  // a line of n printable-or-not chars, CRs sprinkled in, closed by a newline
  task automatic send_line(int n, bit burst);
    for (int k = 0; k < n; k++) begin
      send_item(lar_pkg::OP_BYTE, line_char());
      sender_gap(burst);
    end
    send_item(lar_pkg::OP_BYTE, lar_pkg::CH_NEWLINE);
    sender_gap(burst);
  endtask

  initial begin
    int poll_pct;
    int steps;
    int r;
    bit burst;
    sb      = new();
    rst     = 1'b1;
    start   = 1'b0;
    opcode  = lar_pkg::OP_BYTE;
    rx_byte = 8'h00;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty ring, byte extremes, CR skip, empty lines, poll with junk data
    send_item(lar_pkg::OP_POLL, 8'h00);
    send_item(lar_pkg::OP_BYTE, 8'h00);
    send_item(lar_pkg::OP_BYTE, 8'hFF);
    send_item(lar_pkg::OP_BYTE, lar_pkg::CH_RETURN);
    send_item(lar_pkg::OP_BYTE, 8'h41);
    send_item(lar_pkg::OP_BYTE, lar_pkg::CH_NEWLINE);
    send_item(lar_pkg::OP_BYTE, lar_pkg::CH_NEWLINE);
    send_item(lar_pkg::OP_POLL, 8'hFF);
    send_item(lar_pkg::OP_POLL, 8'hA5);
    send_item(lar_pkg::OP_BYTE, lar_pkg::CH_RETURN);
    send_item(lar_pkg::OP_BYTE, lar_pkg::CH_NEWLINE);
    send_item(lar_pkg::OP_BYTE, 8'h55);
    send_item(lar_pkg::OP_BYTE, 8'hAA);
    send_item(lar_pkg::OP_BYTE, lar_pkg::CH_NEWLINE);
    send_item(lar_pkg::OP_POLL, 8'h5A);
    send_item(lar_pkg::OP_POLL, 8'h00);
    wait_drained();

    // longest line, an overlong one, then fill the ring past capacity
    send_line(LMAX - 1, 1'b1);
    send_line(LMAX + 3, 1'b0);
    for (int i = 0; i < RDEPTH + 1; i++) send_line($urandom_range(1, 4), 1'b0);
    for (int i = 0; i < RDEPTH + 1; i++) begin
      send_item(lar_pkg::OP_POLL, 8'($urandom_range(0, 255)));
      sender_gap(1'b0);
    end
    wait_drained();

    // random phases: fill, drain or mixed, some without idle cycles
    while (sb.transfers < RAND_ITEMS) begin
      r        = $urandom_range(0, 2);
      poll_pct = (r == 0) ? 5 : (r == 1) ? 60 : 30;
      burst    = ($urandom_range(0, 3) == 0);
      steps    = $urandom_range(15, 30);
      for (int s = 0; s < steps && sb.transfers < RAND_ITEMS; s++) begin
        r = $urandom_range(0, 99);
        if (r < poll_pct) begin
          send_item(lar_pkg::OP_POLL, 8'($urandom_range(0, 255)));
          sender_gap(burst);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) send_line($urandom_range(1, 10), burst);
          else if (r < 80) send_line(0, burst);
          else if (r < 85) send_line(LMAX - 1, burst);
          else if (r < 88) send_line($urandom_range(LMAX, LMAX + 6), burst);
          else begin
            // noise: raw bytes, newlines and CRs included
            for (int k = 0; k < 6; k++) begin
              r = $urandom_range(0, 3);
              send_item(lar_pkg::OP_BYTE,
                        (r == 0) ? lar_pkg::CH_NEWLINE :
                        (r == 1) ? lar_pkg::CH_RETURN :
                        8'($urandom_range(0, 255)));
              sender_gap(burst);
            end
          end
        end
      end
      wait_drained();
    end

    // flush whatever is still stored
    for (int i = 0; i < RDEPTH; i++) send_item(lar_pkg::OP_POLL, 8'($urandom_range(0, 255)));
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d transfers: %0d lines stored, %0d dropped on full ring, %0d overlong.",
             sb.transfers, sb.lines_stored, sb.lines_full_drop, sb.lines_overlong);
    $display("Polls: %0d returned a line, %0d on empty ring; %0d result beats checked.",
             sb.line_polls, sb.empty_polls, sb.results_seen);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS line_assembler_ring_top");
    end else begin
      $display("FAIL line_assembler_ring_top");
    end
    $finish;
  end

endmodule

// ----- line_assembler_ring_top.f -----
+incdir+rtl
rtl/lar_pkg.sv
rtl/lar_front.sv
rtl/lar_back.sv
rtl/line_assembler_ring_top.sv
rtl/lar_checker.sv
tb/tb_top.sv
